>>> src/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants for the depth-first topological sorter: port
// widths, action codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package dts_pkg;

    // default sizes of the graph storage
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_DEGREE   = 8;

    // port field widths
    localparam int VERTEX_W   = 6;
    localparam int ACTION_W   = 2;
    localparam int CFG_W      = 7;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // vertex count after reset
    localparam logic [CFG_W-1:0] VCOUNT_RST = 7'd64;

    // input action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_SORT  = 2'd2
    } t_action;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_ROOT,
        S_DEG,
        S_EDGE,
        S_NB,
        S_RESTORE,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear_graph;   // drop all adjacency lists, clear overflow
        logic add_read;      // latch edge, read degree of its source
        logic add_commit;    // store edge or flag overflow
        logic sort_init;     // clear visited map and stacks, root to zero
        logic root_next;     // advance root vertex
        logic root_start;    // open a search at the root vertex
        logic deg_capture;   // take degree of the current vertex
        logic edge_read;     // read next neighbor of the current vertex
        logic vertex_finish; // pop current vertex onto the finish stack
        logic push_nb;       // descend into the neighbor just read
        logic restore;       // resume the parent vertex from the stack
        logic emit_read;     // read the top of the finish stack
        logic emit_pop;      // drop the top of the finish stack
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic root_done;     // every root vertex has been tried
        logic root_visited;  // current root already reached
        logic edge_left;     // current vertex has unread neighbors
        logic nb_push_ok;    // neighbor just read may be entered
        logic depth_one;     // search stack holds only the current vertex
        logic fsp_one;       // finish stack holds one vertex
    } t_dp_sts;

endpackage

>>> src/dts_ctrl.sv
// ----------------------------------------------------------------------------
// dts_ctrl
// Controller state machine: decodes input actions, sequences the search
// over the datapath and paces the emitted order.
// ----------------------------------------------------------------------------
module dts_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [dts_pkg::ACTION_W-1:0]     i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    input  dts_pkg::t_dp_sts                 i_sts,
    output dts_pkg::t_dp_cmd                 o_cmd
);
    import dts_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   in_xfer;

    // input transfer, ready only while idle
    assign in_xfer = i_s_axis_tvalid && (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (in_xfer) begin
                    case (t_action'(i_s_axis_tuser))
                        ACT_CLEAR: begin
                            o_cmd.clear_graph = 1'b1;
                        end
                        ACT_ADD: begin
                            o_cmd.add_read = 1'b1;
                            n_state        = S_ADD;
                        end
                        ACT_SORT: begin
                            o_cmd.sort_init = 1'b1;
                            n_state         = S_ROOT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD: begin
                o_cmd.add_commit = 1'b1;
                n_state          = S_IDLE;
            end
            S_ROOT: begin
                if (i_sts.root_done) begin
                    n_state = S_EMIT_RD;
                end else if (i_sts.root_visited) begin
                    o_cmd.root_next = 1'b1;
                end else begin
                    o_cmd.root_start = 1'b1;
                    n_state          = S_DEG;
                end
            end
            S_DEG: begin
                o_cmd.deg_capture = 1'b1;
                n_state           = S_EDGE;
            end
            S_EDGE: begin
                if (i_sts.edge_left) begin
                    o_cmd.edge_read = 1'b1;
                    n_state         = S_NB;
                end else begin
                    o_cmd.vertex_finish = 1'b1;
                    if (i_sts.depth_one) begin
                        o_cmd.root_next = 1'b1;
                        n_state         = S_ROOT;
                    end else begin
                        n_state = S_RESTORE;
                    end
                end
            end
            S_NB: begin
                if (i_sts.nb_push_ok) begin
                    o_cmd.push_nb = 1'b1;
                    n_state       = S_DEG;
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_RESTORE: begin
                o_cmd.restore = 1'b1;
                n_state       = S_DEG;
            end
            S_EMIT_RD: begin
                o_cmd.emit_read = 1'b1;
                n_state         = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                o_m_axis_tvalid = 1'b1;
                if (i_m_axis_tready) begin
                    o_cmd.emit_pop = 1'b1;
                    n_state        = i_sts.fsp_one ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/dts_datapath.sv
// ----------------------------------------------------------------------------
// dts_datapath
// Graph storage and search datapath: adjacency and degree memories, the
// search and finish stacks, visited map, counters and the output register.
// ----------------------------------------------------------------------------
module dts_datapath #(
    parameter int MAX_VERTICES = dts_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = dts_pkg::DEF_MAX_DEGREE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dts_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic [dts_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    input  dts_pkg::t_dp_cmd                 i_cmd,
    output dts_pkg::t_dp_sts                 o_sts,
    output logic [dts_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    output logic                             o_m_axis_tuser
);
    import dts_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_DEGREE + 1);
    localparam int DW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int SW = VW + EW;

    // memories
    logic [VW-1:0] adj_mem [MAX_VERTICES*MAX_DEGREE];
    logic [EW-1:0] deg_mem [MAX_VERTICES];
    logic [SW-1:0] stk_mem [MAX_VERTICES];
    logic [VW-1:0] fin_mem [MAX_VERTICES];

    // registers
    logic [CFG_W-1:0]        r_vcount;
    logic                    r_overflow;
    logic [MAX_VERTICES-1:0] r_deg_vld;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [VERTEX_W-1:0]     r_add_src;
    logic [VERTEX_W-1:0]     r_add_dst;
    logic [EW-1:0]           r_deg_rd;
    logic                    r_deg_rd_vld;
    logic [VW-1:0]           r_adj_rd;
    logic [SW-1:0]           r_stk_rd;
    logic [VW-1:0]           r_fin_rd;
    logic [DW-1:0]           r_root;
    logic [DW-1:0]           r_depth;
    logic [DW-1:0]           r_fsp;
    logic [VW-1:0]           r_cur_v;
    logic [EW-1:0]           r_cur_e;
    logic [EW-1:0]           r_cur_deg;

    // combinational helpers
    logic [CFG_W-1:0]    n_eff;
    logic [EW-1:0]       deg_eff;
    logic                add_bad;
    logic                deg_rd_en;
    logic [VW-1:0]       deg_rd_addr;
    logic [VW-1:0]       in_src;
    logic [VW-1:0]       stk_rd_v;
    logic [EW-1:0]       stk_rd_e;
    logic [AW-1:0]       add_addr;
    logic [AW-1:0]       edge_addr;

    assign in_src   = i_s_axis_tdata[VW-1:0];
    assign stk_rd_v = r_stk_rd[SW-1:EW];
    assign stk_rd_e = r_stk_rd[EW-1:0];

    // vertices in use, kept between one and the storage size
    always_comb begin
        if (r_vcount == '0) begin
            n_eff = CFG_W'(1);
        end else if (r_vcount > CFG_W'(MAX_VERTICES)) begin
            n_eff = CFG_W'(MAX_VERTICES);
        end else begin
            n_eff = r_vcount;
        end
    end

    // edge insertion checks
    assign deg_eff  = r_deg_rd_vld ? r_deg_rd : '0;
    assign add_bad  = (CFG_W'(r_add_src) >= n_eff) || (CFG_W'(r_add_dst) >= n_eff)
                   || (deg_eff >= EW'(MAX_DEGREE));
    assign add_addr  = AW'(r_add_src[VW-1:0]) * AW'(MAX_DEGREE) + AW'(deg_eff);
    assign edge_addr = AW'(r_cur_v) * AW'(MAX_DEGREE) + AW'(r_cur_e);

    // degree read address select
    always_comb begin
        deg_rd_en   = 1'b1;
        deg_rd_addr = r_adj_rd;
        if (i_cmd.add_read) begin
            deg_rd_addr = in_src;
        end else if (i_cmd.root_start) begin
            deg_rd_addr = r_root[VW-1:0];
        end else if (i_cmd.restore) begin
            deg_rd_addr = stk_rd_v;
        end else if (!i_cmd.push_nb) begin
            deg_rd_en = 1'b0;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.root_done    = CFG_W'(r_root) >= n_eff;
        o_sts.root_visited = r_visited[r_root[VW-1:0]];
        o_sts.edge_left    = r_cur_e < r_cur_deg;
        o_sts.nb_push_ok   = (CFG_W'(r_adj_rd) < n_eff) && !r_visited[r_adj_rd]
                          && (r_depth < DW'(MAX_VERTICES));
        o_sts.depth_one    = r_depth == DW'(1);
        o_sts.fsp_one      = r_fsp == DW'(1);
    end

    // adjacency memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_commit && !add_bad) begin
            adj_mem[add_addr] <= r_add_dst[VW-1:0];
        end
        if (i_cmd.edge_read) begin
            r_adj_rd <= adj_mem[edge_addr];
        end
    end

    // degree memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_commit && !add_bad) begin
            deg_mem[r_add_src[VW-1:0]] <= deg_eff + EW'(1);
        end
        if (deg_rd_en) begin
            r_deg_rd <= deg_mem[deg_rd_addr];
        end
    end

    // search stack memory, parents of the current vertex
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_nb) begin
            stk_mem[VW'(r_depth - DW'(1))] <= {r_cur_v, r_cur_e};
        end
        if (i_cmd.vertex_finish) begin
            r_stk_rd <= stk_mem[VW'(r_depth - DW'(2))];
        end
    end

    // finish stack memory, read data doubles as output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.vertex_finish && (r_fsp < DW'(MAX_VERTICES))) begin
            fin_mem[r_fsp[VW-1:0]] <= r_cur_v;
        end
        if (i_cmd.emit_read) begin
            r_fin_rd <= fin_mem[VW'(r_fsp - DW'(1))];
        end
    end

    // edge latch, degree valid sample and current vertex registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_read) begin
            r_add_src <= i_s_axis_tdata[VERTEX_W-1:0];
            r_add_dst <= i_s_axis_tdata[2*VERTEX_W-1:VERTEX_W];
        end
        if (deg_rd_en) begin
            r_deg_rd_vld <= r_deg_vld[deg_rd_addr];
        end
        if (i_cmd.deg_capture) begin
            r_cur_deg <= r_deg_rd_vld ? r_deg_rd : '0;
        end
        if (i_cmd.root_start) begin
            r_cur_v <= r_root[VW-1:0];
            r_cur_e <= '0;
        end else if (i_cmd.push_nb) begin
            r_cur_v <= r_adj_rd;
            r_cur_e <= '0;
        end else if (i_cmd.restore) begin
            r_cur_v <= stk_rd_v;
            r_cur_e <= stk_rd_e;
        end else if (i_cmd.edge_read) begin
            r_cur_e <= r_cur_e + EW'(1);
        end
    end

    // control state: config, flags, valid bits, visited map, counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount   <= VCOUNT_RST;
            r_overflow <= 1'b0;
            r_deg_vld  <= '0;
            r_visited  <= '0;
            r_root     <= '0;
            r_depth    <= '0;
            r_fsp      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            if (i_cmd.clear_graph) begin
                r_overflow <= 1'b0;
                r_deg_vld  <= '0;
            end
            if (i_cmd.add_commit) begin
                if (add_bad) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_deg_vld[r_add_src[VW-1:0]] <= 1'b1;
                end
            end
            if (i_cmd.sort_init) begin
                r_visited <= '0;
                r_root    <= '0;
                r_depth   <= '0;
                r_fsp     <= '0;
            end
            if (i_cmd.root_next) begin
                r_root <= r_root + DW'(1);
            end
            if (i_cmd.root_start) begin
                r_visited[r_root[VW-1:0]] <= 1'b1;
                r_depth                   <= DW'(1);
            end
            if (i_cmd.push_nb) begin
                r_visited[r_adj_rd] <= 1'b1;
                r_depth             <= r_depth + DW'(1);
            end
            if (i_cmd.vertex_finish) begin
                r_depth <= r_depth - DW'(1);
                if (r_fsp < DW'(MAX_VERTICES)) begin
                    r_fsp <= r_fsp + DW'(1);
                end
            end
            if (i_cmd.emit_pop) begin
                r_fsp <= r_fsp - DW'(1);
            end
        end
    end

    // result payload
    assign o_m_axis_tdata = OUT_DATA_W'(r_fin_rd);
    assign o_m_axis_tuser = r_overflow;

endmodule

>>> src/dfs_topological_sort.sv
// ----------------------------------------------------------------------------
// dfs_topological_sort
// Loads a directed graph edge by edge and orders its vertices by depth-first
// search, emitting them in reverse postorder.
//
//   channel   dir  handshake         payload
//   s_axis    in   tvalid / tready   tdata: src_vertex[5:0], dst_vertex[11:6]
//                                    tuser: action[1:0]
//   m_axis    out  tvalid / tready   tdata: vertex_out[5:0]; tlast:
//                                    last_in_order; tuser: edge_overflow
//   cfg       in   we                wdata: vertex_count[6:0]
//
// Clear is taken in the idle state; add edge reads the degree, then appends to the list.
// A sort tries each root in turn, scans the edges of each vertex entered, moves
// each vertex left onto the finish stack and resumes the parent of each non-root
// vertex; then each vertex is read from the finish stack and emitted.
// Reset clears state, counters, overflow and degree valid bits at once.
// Input is held off during a sort or emit; a stalled result holds in place.
// ----------------------------------------------------------------------------
module dfs_topological_sort #(
    parameter int MAX_VERTICES = dts_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = dts_pkg::DEF_MAX_DEGREE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write
    input  logic                             i_cfg_we,
    input  logic [dts_pkg::CFG_W-1:0]        i_cfg_wdata,    // vertex_count
    // input stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [dts_pkg::IN_DATA_W-1:0]    i_s_axis_tdata, // src_vertex, dst_vertex
    input  logic [dts_pkg::ACTION_W-1:0]     i_s_axis_tuser, // action
    // output stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [dts_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata, // vertex_out
    output logic                             o_m_axis_tlast, // last_in_order
    output logic                             o_m_axis_tuser  // edge_overflow
);
    import dts_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing
    dts_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    // storage and search datapath
    dts_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    // final vertex of the order
    assign o_m_axis_tlast = sts.fsp_one;

endmodule
